/* rtl/sfd_pkg.sv */
// Shared types and constants for the serial frame deframer.
`default_nettype none

package sfd_pkg;

  localparam int unsigned SFD_MAX_PAYLOAD = 256;

  localparam logic [7:0] START_BYTE = 8'hFA;
  localparam logic [7:0] END_BYTE   = 8'h5F;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_FUNC     = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_LEN_HI   = 3'd3,
    PH_ID       = 3'd4,
    PH_PAYLOAD  = 3'd5,
    PH_WAIT_END = 3'd6
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_DONE    = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] function_code;
    logic [7:0] message_id;
    logic [8:0] frame_length;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
  } sfd_result_t;

  typedef struct packed {
    logic        valid;
    sfd_result_t data;
  } sfd_result_req_t;

endpackage

`default_nettype wire

/* rtl/sfd_byte_if.sv */
// Received byte channel: valid/ready handshake carrying one serial byte.
`default_nettype none

interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/sfd_result_if.sv */
// Result channel: valid/ready handshake carrying one deframer result.
`default_nettype none

interface sfd_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] function_code;
  logic [7:0] message_id;
  logic [8:0] frame_length;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;

  modport source (
    output valid, output result_kind, output function_code, output message_id,
    output frame_length, output payload_byte, output byte_index, input ready
  );
  modport sink (
    input valid, input result_kind, input function_code, input message_id,
    input frame_length, input payload_byte, input byte_index, output ready
  );
endinterface

`default_nettype wire

/* rtl/sfd_parser.sv */
// Frame parser state machine: tracks the frame fields and builds one result per payload byte and one at the end byte.
`default_nettype none

module sfd_parser
  import sfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = SFD_MAX_PAYLOAD
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  output sfd_result_req_t      result
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  phase_t            phase;
  phase_t            phase_next;
  logic [7:0]        frame_function;
  logic [15:0]       frame_len;
  logic [7:0]        frame_id;
  logic [CNT_W-1:0]  payload_count;

  logic [15:0] len_full;
  logic [15:0] cnt_ext;
  logic [15:0] cnt_inc;
  logic [15:0] last_count;

  assign len_full   = {rx_byte, frame_len[7:0]};
  assign cnt_ext    = 16'(payload_count);
  assign cnt_inc    = cnt_ext + 16'd1;
  // zero length behaves like one: no payload bytes
  assign last_count = (frame_len == 16'd0) ? 16'd0 : frame_len - 16'd1;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_FUNC:     phase_next = PH_LEN_LO;
      PH_LEN_LO:   phase_next = PH_LEN_HI;
      PH_LEN_HI:   phase_next = (len_full > MAX_LEN) ? PH_HUNT : PH_ID;
      PH_ID:       phase_next = (frame_len <= 16'd1) ? PH_WAIT_END : PH_PAYLOAD;
      PH_PAYLOAD:  phase_next = (cnt_inc >= last_count) ? PH_WAIT_END : PH_PAYLOAD;
      PH_WAIT_END: phase_next = (rx_byte == END_BYTE) ? PH_HUNT : PH_WAIT_END;
      default:     phase_next = (rx_byte == START_BYTE) ? PH_FUNC : PH_HUNT;
    endcase
  end

  always_comb begin
    result.valid              = 1'b0;
    result.data.result_kind   = KIND_PAYLOAD;
    result.data.function_code = frame_function;
    result.data.message_id    = frame_id;
    result.data.frame_length  = frame_len[8:0];
    result.data.payload_byte  = 8'd0;
    result.data.byte_index    = 8'd0;
    case (phase)
      PH_PAYLOAD: begin
        result.valid             = accept;
        result.data.payload_byte = rx_byte;
        result.data.byte_index   = cnt_ext[7:0];
      end
      PH_WAIT_END: begin
        result.valid            = accept && (rx_byte == END_BYTE);
        result.data.result_kind = KIND_DONE;
      end
      default: begin
        result.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_function <= '0;
      frame_len      <= '0;
      frame_id       <= '0;
      payload_count  <= '0;
    end else if (accept) begin
      case (phase)
        PH_FUNC:    frame_function <= rx_byte;
        PH_LEN_LO:  frame_len      <= {8'd0, rx_byte};
        PH_LEN_HI:  frame_len      <= len_full;
        PH_ID: begin
          frame_id      <= rx_byte;
          payload_count <= '0;
        end
        PH_PAYLOAD: payload_count  <= cnt_inc[CNT_W-1:0];
        default: begin
          frame_id <= frame_id;
        end
      endcase
    end
  end

  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (accept && (phase == PH_PAYLOAD || phase == PH_WAIT_END)))
    else $error("result raised outside payload or end phase");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (cnt_ext < last_count))
    else $error("payload index ran past frame length");

  a_long_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_LEN_HI && len_full > MAX_LEN) |=> (phase == PH_HUNT))
    else $error("over-long frame not dropped");

endmodule

`default_nettype wire

/* rtl/sfd_result_reg.sv */
// Result register between the parser and the result channel.
`default_nettype none

module sfd_result_reg
  import sfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  sfd_result_req_t       result,
  output logic                  load_ready,
  sfd_result_if.source          out_ch
);

  logic        valid;
  sfd_result_t data;

  // free when empty or when the held result transfers this cycle
  assign load_ready = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && result.valid) begin
      data <= result.data;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.result_kind   = data.result_kind;
  assign out_ch.function_code = data.function_code;
  assign out_ch.message_id    = data.message_id;
  assign out_ch.frame_length  = data.frame_length;
  assign out_ch.payload_byte  = data.payload_byte;
  assign out_ch.byte_index    = data.byte_index;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_ch.ready) |-> !load_ready)
    else $error("held result could be overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load_ready && result.valid) |=> valid)
    else $error("loaded result not presented");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (valid && out_ch.ready && !result.valid) |=> !valid)
    else $error("transferred result still shown");

endmodule

`default_nettype wire

/* rtl/serial_frame_deframer.sv */
// Top level of the serial frame deframer.
// A result is registered as its byte transfers in and shows on the output in the next cycle.
// Throughput: one byte per cycle while results drain; parser state updates as a byte is taken.
// Input ready follows the single result register: high when it is empty or draining.
// Reset (rst, synchronous): parser hunts for the start byte, frame fields clear, no result held.
`default_nettype none

module serial_frame_deframer
  import sfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = SFD_MAX_PAYLOAD
) (
  input  wire logic    clk,
  input  wire logic    rst,
  sfd_byte_if.sink     bytes,
  sfd_result_if.source results
);

  logic            accept;
  logic            load_ready;
  sfd_result_req_t result;

  assign bytes.ready = load_ready;
  assign accept      = bytes.valid && load_ready;

  sfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (bytes.rx_byte),
    .result  (result)
  );

  sfd_result_reg u_result_reg (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .load_ready (load_ready),
    .out_ch     (results)
  );

endmodule

`default_nettype wire

/* sim/serial_frame_deframer_tb.sv */
// Self-checking testbench for the serial frame deframer: byte stimulus, frame predictor, result checks.
`default_nettype none

module serial_frame_deframer_tb
  import sfd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TARGET_BYTES  = 950;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 20;

  // Frame predictor and the queue of results it expects, oldest first.
  class frame_predictor;
    phase_t             phase;
    logic [7:0]         fn_code;
    logic [7:0]         msg_id;
    logic [15:0]        len_field;
    logic [15:0]        pay_count;
    sfd_result_t        awaited[$];
    int                 mismatches;

    function new();
      phase      = PH_HUNT;
      fn_code    = '0;
      msg_id     = '0;
      len_field  = '0;
      pay_count  = '0;
      mismatches = 0;
    endfunction

    function void push_result(kind_t kind, logic [7:0] data, logic [7:0] idx);
      sfd_result_t r;
      r.result_kind   = kind;
      r.function_code = fn_code;
      r.message_id    = msg_id;
      r.frame_length  = len_field[8:0];
      r.payload_byte  = data;
      r.byte_index    = idx;
      awaited.push_back(r);
    endfunction

    // Advance the predictor by one transferred byte.
    function void take_byte(logic [7:0] b);
      logic [15:0] eff_len;
      case (phase)
        PH_FUNC: begin
          fn_code = b;
          phase   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_field = {8'h00, b};
          phase     = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_field[15:8] = b;
          phase = (len_field > SFD_MAX_PAYLOAD) ? PH_HUNT : PH_ID;
        end
        PH_ID: begin
          msg_id    = b;
          pay_count = '0;
          phase     = (len_field <= 16'd1) ? PH_WAIT_END : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          push_result(KIND_PAYLOAD, b, pay_count[7:0]);
          pay_count = pay_count + 16'd1;
          eff_len   = (len_field == 16'd0) ? 16'd1 : len_field;
          if (pay_count >= eff_len - 16'd1) phase = PH_WAIT_END;
        end
        PH_WAIT_END: begin
          if (b == END_BYTE) begin
            phase = PH_HUNT;
            push_result(KIND_DONE, 8'h00, 8'h00);
          end
        end
        default: begin
          phase = (b == START_BYTE) ? PH_FUNC : PH_HUNT;
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task check_result(sfd_result_t got);
      sfd_result_t exp;
      bit          bad;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      exp = awaited.pop_front();
      bad = 1'b0;
      if (got.result_kind   !== exp.result_kind)   bad = 1'b1;
      if (got.function_code !== exp.function_code) bad = 1'b1;
      if (got.message_id    !== exp.message_id)    bad = 1'b1;
      if (got.frame_length  !== exp.frame_length)  bad = 1'b1;
      if (got.payload_byte  !== exp.payload_byte)  bad = 1'b1;
      if (got.byte_index    !== exp.byte_index)    bad = 1'b1;
      if (bad) report_mismatch($sformatf("got %p, expected %p", got, exp));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfd_byte_if   bytes_ch ();
  sfd_result_if results_ch ();

  serial_frame_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_ch),
    .results (results_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_predictor predictor = new();

  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned sink_wait   = 0;
  bit          calm        = 1'b0;

  // Transfer monitor, result checks and the no-progress watchdog.
  always @(posedge clk) begin
    sfd_result_t got;
    if (!rst) begin
      idle_cycles++;
      if (results_ch.valid && results_ch.ready) begin
        got.result_kind   = kind_t'(results_ch.result_kind);
        got.function_code = results_ch.function_code;
        got.message_id    = results_ch.message_id;
        got.frame_length  = results_ch.frame_length;
        got.payload_byte  = results_ch.payload_byte;
        got.byte_index    = results_ch.byte_index;
        predictor.check_result(got);
        sink_wait   = calm ? 0 : $urandom_range(0, 12);
        idle_cycles = 0;
      end
      if (bytes_ch.valid && bytes_ch.ready) begin
        predictor.take_byte(bytes_ch.rx_byte);
        idle_cycles = 0;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[serial_frame_deframer] ERROR");
        $finish;
      end
    end
  end

  // Result side: hold ready low for the drawn stall, then wait for a transfer.
  always @(negedge clk) begin
    if (rst) begin
      results_ch.ready = 1'b0;
    end else if (sink_wait > 0) begin
      results_ch.ready = 1'b0;
      sink_wait--;
    end else begin
      results_ch.ready = 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      bytes_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    bytes_ch.valid   = 1'b1;
    bytes_ch.rx_byte = b;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] any_but_end();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == END_BYTE) b = ~b;
    return b;
  endfunction

  // Broken frames stop at a random point in the payload and never close.
  task automatic send_frame(input logic [7:0] fn, input logic [15:0] len,
                            input logic [7:0] mid, input int junk, input bit broken);
    int n_pay;
    send_byte(START_BYTE);
    send_byte(fn);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len > SFD_MAX_PAYLOAD) return;
    send_byte(mid);
    n_pay = (len == 16'd0) ? 0 : int'(len) - 1;
    if (broken) n_pay = $urandom_range(0, n_pay);
    repeat (n_pay) send_byte(8'($urandom_range(0, 255)));
    if (!broken) begin
      repeat (junk) send_byte(any_but_end());
      send_byte(END_BYTE);
    end
  endtask

  logic [7:0] opening[] = '{
    // noise while hunting, including a lone end byte
    8'h00, 8'hFF, END_BYTE,
    // zero length, a start byte skipped while waiting for the end
    START_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF, START_BYTE, END_BYTE,
    // length one: no payload
    START_BYTE, 8'hFF, 8'h01, 8'h00, 8'h00, END_BYTE,
    // two payload bytes at the extremes
    START_BYTE, 8'h5A, 8'h03, 8'h00, 8'hA5, 8'h00, 8'hFF, END_BYTE,
    // length one above the limit: dropped
    START_BYTE, 8'h01, 8'h01, 8'h01
  };

  initial begin
    int  pick;
    bit  drained_once;
    bytes_ch.valid   = 1'b0;
    bytes_ch.rx_byte = 8'h00;
    results_ch.ready = 1'b0;
    drained_once     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening[i]) send_byte(opening[i]);

    // longest legal frame (the limit exactly), then the widest over-long length
    send_frame(8'($urandom_range(0, 255)), 16'(SFD_MAX_PAYLOAD),
               8'($urandom_range(0, 255)), 0, 1'b0);
    send_frame(8'h33, 16'hFFFF, 8'h44, 0, 1'b0);

    while (bytes_sent < TARGET_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 15) begin
        send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(257, 65535)),
                   8'($urandom_range(0, 255)), 0, 1'b0);
      end else if (pick < 22) begin
        send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 12)),
                   8'($urandom_range(0, 255)), 0, 1'b1);
      end else begin
        send_frame(8'($urandom_range(0, 255)),
                   (pick == 22) ? 16'($urandom_range(9, 256)) : 16'($urandom_range(0, 8)),
                   8'($urandom_range(0, 255)),
                   ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3), 1'b0);
      end
      // hold the sender once until every pending result has drained
      if (!drained_once && bytes_sent >= TARGET_BYTES / 2) begin
        drained_once   = 1'b1;
        bytes_ch.valid = 1'b0;
        while (predictor.awaited.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 15) == 0) calm = ~calm;
    end

    bytes_ch.valid = 1'b0;
    while (predictor.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (predictor.awaited.size() != 0)
      predictor.report_mismatch($sformatf("missing result %p", predictor.awaited.pop_front()));

    if (predictor.mismatches == 0) begin
      $display("[serial_frame_deframer] OK");
    end else begin
      $display("[serial_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
